// ===== rtl/fvqs_pkg.sv =====
package fvqs_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 12;
  localparam int CFG_W = 12;
  localparam int SLOTS = 3;

  // Four-tap kernel weights and rounding
  localparam int TAP_NEAR_PREV = 9;
  localparam int TAP_CENTER    = 111;
  localparam int TAP_NEXT      = 29;
  localparam int TAP_FAR       = 3;
  localparam int TAP_ROUND     = 64;
  localparam int TAP_SHIFT     = 7;
  // Bias that keeps the accumulator non-negative, removed after the shift
  localparam int TAP_BIAS_Q    = 24;

  typedef enum logic [1:0] {
    REG_KERNEL_SELECT = 2'd0,
    REG_SHIFT_UP      = 2'd1,
    REG_LINE_WIDTH    = 2'd2,
    REG_FIELD_HEIGHT  = 2'd3
  } cfg_reg_t;

  // Source rows at one column: [0] current, [1..3] one to three rows above
  typedef logic [3:0][PIX_W-1:0] win_t;

  // Up to three result pixels caused by one source pixel
  typedef struct packed {
    logic [1:0]                   count;
    logic [SLOTS-1:0][ROW_W-1:0]  row;
    logic [SLOTS-1:0][PIX_W-1:0]  pix;
    logic [SLOTS-1:0]             eof;
  } group_t;

endpackage

// ===== rtl/fvqs_kernel.sv =====
module fvqs_kernel import fvqs_pkg::*; (
  input  win_t             win,
  input  logic [ROW_W-1:0] cur_row,
  input  logic [ROW_W-1:0] height,
  input  logic             last_col,
  input  logic             kernel_select,
  input  logic             shift_up,
  output group_t           grp
);

  // Pick the source row k from the window relative to the current row
  function automatic logic [PIX_W-1:0] src(input win_t w, input logic [ROW_W-1:0] cur,
                                           input logic [ROW_W-1:0] k);
    logic [1:0] d;
    d = 2'(cur - k);
    return w[d];
  endfunction

  function automatic logic [PIX_W-1:0] lin(input logic [PIX_W-1:0] n,
                                           input logic [PIX_W-1:0] c,
                                           input logic [1:0] rnd);
    logic [PIX_W+1:0] s;
    s = (PIX_W+2)'(n) + (PIX_W+2)'({c, 1'b0}) + (PIX_W+2)'(c) + (PIX_W+2)'(rnd);
    return s[PIX_W+1:2];
  endfunction

  function automatic logic [PIX_W-1:0] taps(input logic [PIX_W-1:0] pm,
                                            input logic [PIX_W-1:0] c,
                                            input logic [PIX_W-1:0] pn,
                                            input logic [PIX_W-1:0] pnn);
    logic [16:0] acc;
    logic [9:0]  v;
    acc = 17'(c) * 17'(TAP_CENTER) + 17'(pn) * 17'(TAP_NEXT)
        + 17'(TAP_ROUND + (TAP_BIAS_Q << TAP_SHIFT))
        - 17'(pm) * 17'(TAP_NEAR_PREV) - 17'(pnn) * 17'(TAP_FAR);
    v = acc[16:TAP_SHIFT];
    if (v < 10'(TAP_BIAS_Q)) begin
      return '0;
    end else if (v - 10'(TAP_BIAS_Q) > 10'((1 << PIX_W) - 1)) begin
      return '1;
    end else begin
      return PIX_W'(v - 10'(TAP_BIAS_Q));
    end
  endfunction

  function automatic logic [PIX_W-1:0] out_pixel(input win_t w,
                                                 input logic [ROW_W-1:0] cur,
                                                 input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] h,
                                                 input logic ks, input logic su);
    logic [ROW_W-1:0] hm1;
    logic [ROW_W-1:0] hm2;
    logic [ROW_W-1:0] one;
    hm1 = h - ROW_W'(1);
    hm2 = h - ROW_W'(2);
    one = ROW_W'(1);
    if (!ks) begin
      if (!su) begin
        return (r == hm1) ? src(w, cur, r) : lin(src(w, cur, r + one), src(w, cur, r), 2'd0);
      end
      return (r == '0) ? src(w, cur, '0) : lin(src(w, cur, r - one), src(w, cur, r), 2'd0);
    end
    if (!su) begin
      if (r == hm1) begin
        return src(w, cur, r);
      end else if (r == '0 || r == hm2) begin
        return lin(src(w, cur, r + one), src(w, cur, r), 2'd2);
      end
      return taps(src(w, cur, r - one), src(w, cur, r), src(w, cur, r + one),
                  src(w, cur, r + ROW_W'(2)));
    end
    if (r == '0) begin
      return src(w, cur, '0);
    end else if (r == one || r == hm1) begin
      return lin(src(w, cur, r - one), src(w, cur, r), 2'd2);
    end
    return taps(src(w, cur, r + one), src(w, cur, r), src(w, cur, r - one),
                src(w, cur, r - ROW_W'(2)));
  endfunction

  logic [1:0]       look;
  logic [ROW_W-1:0] hm1;
  logic             at_end;
  logic             ahead;
  logic [ROW_W-1:0] first;
  logic [ROW_W-1:0] last;
  logic [ROW_W-1:0] r;

  // Work out which output rows this source pixel completes, then filter each
  always_comb begin
    look   = {1'b0, kernel_select} + {1'b0, ~shift_up};
    hm1    = height - ROW_W'(1);
    at_end = (cur_row == hm1);
    ahead  = (cur_row >= ROW_W'(look));
    last   = at_end ? hm1 : cur_row - ROW_W'(look);
    first  = ahead ? cur_row - ROW_W'(look) : '0;
    grp.count = (ahead || at_end) ? 2'(last - first + ROW_W'(1)) : 2'd0;
    for (int j = 0; j < SLOTS; j++) begin
      r = first + ROW_W'(j);
      grp.row[j] = r;
      grp.pix[j] = out_pixel(win, cur_row, r, height, kernel_select, shift_up);
      grp.eof[j] = (r == hm1) && last_col;
    end
  end

endmodule

// ===== rtl/field_vertical_quarter_shift_unit.sv =====
// Channel  Signals                                            Transfer
// input    in_valid, in_ready, pixel_in                       in_valid && in_ready
// output   out_valid, out_ready, pixel_out, out_row, out_col,
//          last_of_item, last_of_field                        out_valid && out_ready
// config   cfg_valid, cfg_ready, cfg_index, cfg_data          cfg_valid && cfg_ready
//
// One source pixel per cycle unless the output stalls; stage 1 feeds the output register.
// Rows that flush at the end of the field give up to three results for one pixel; the
// output register sends one a cycle while out_ready holds; the next group waits in stage 1.
// Reset (rst, synchronous) restores the register defaults and restarts at row 0, column 0.
// A stalled output holds the input side only once both pipeline stages are full.
module field_vertical_quarter_shift_unit import fvqs_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [PIX_W-1:0]             pixel_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [PIX_W-1:0]             pixel_out,
  output logic [ROW_W-1:0]             out_row,
  output logic [$clog2(MAX_WIDTH)-1:0] out_col,
  output logic                         last_of_item,
  output logic                         last_of_field,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic             kernel_select;
  logic             shift_up;
  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] field_height;

  logic [CW-1:0]    column_count;
  logic [ROW_W-1:0] row_count;

  logic [PIX_W-1:0] line_store_a [MAX_WIDTH];
  logic [PIX_W-1:0] line_store_b [MAX_WIDTH];
  logic [PIX_W-1:0] line_store_c [MAX_WIDTH];

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [CW-1:0]    s1_col;
  logic [ROW_W-1:0] s1_row;
  logic             s1_last_col;
  logic [PIX_W-1:0] rd_a;
  logic [PIX_W-1:0] rd_b;
  logic [PIX_W-1:0] rd_c;
  logic             s1_byp;
  logic [PIX_W-1:0] byp_a;
  logic [PIX_W-1:0] byp_b;
  logic [PIX_W-1:0] byp_c;

  logic [1:0]       out_cnt;
  group_t           out_grp;
  logic [CW-1:0]    out_col_q;

  logic [CW:0]      w_eff;
  logic [ROW_W-1:0] h_eff;
  logic             row_wrap;
  logic [ROW_W-1:0] row_cur;
  logic [CW-1:0]    col_cur;
  logic             col_end;
  logic [ROW_W-1:0] row_inc;
  logic             in_xfer;
  logic             out_xfer;
  logic             out_free;
  logic             s1_done;
  win_t             win;
  group_t           grp;

  assign cfg_ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_select <= 1'b1;
      shift_up      <= 1'b0;
      line_width    <= CFG_W'(720);
      field_height  <= CFG_W'(240);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KERNEL_SELECT: kernel_select <= cfg_data[0];
        REG_SHIFT_UP:      shift_up      <= cfg_data[0];
        REG_LINE_WIDTH:    line_width    <= cfg_data;
        REG_FIELD_HEIGHT:  field_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes and position of the incoming pixel
  always_comb begin
    if (line_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(line_width) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(line_width);
    end
    h_eff    = (field_height == '0) ? ROW_W'(1) : field_height;
    row_wrap = (row_count >= h_eff);
    row_cur  = row_wrap ? '0 : row_count;
    col_cur  = (row_wrap || ({1'b0, column_count} >= w_eff)) ? '0 : column_count;
    col_end  = ({1'b0, col_cur} + (CW+1)'(1) >= w_eff);
    row_inc  = ({1'b0, row_cur} + (ROW_W+1)'(1) >= {1'b0, h_eff}) ? '0
             : row_cur + ROW_W'(1);
  end

  assign out_free = (out_cnt == 2'd0) || (out_ready && out_cnt == 2'd1);
  assign s1_done  = s1_valid && (grp.count == 2'd0 || out_free);
  assign in_ready = !s1_valid || s1_done;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Advance raster counters on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_inc;
      end else begin
        column_count <= col_cur + CW'(1);
        row_count    <= row_cur;
      end
    end
  end

  // Line stores: read at transfer, write back the shifted column when the pixel retires
  always_ff @(posedge clk) begin
    if (s1_done) begin
      line_store_a[s1_col] <= win[0];
      line_store_b[s1_col] <= win[1];
      line_store_c[s1_col] <= win[2];
    end
    if (in_xfer) begin
      rd_a <= line_store_a[col_cur];
      rd_b <= line_store_b[col_cur];
      rd_c <= line_store_c[col_cur];
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_done) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload, with a bypass when the retiring pixel writes the column being read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix      <= pixel_in;
      s1_col      <= col_cur;
      s1_row      <= row_cur;
      s1_last_col <= col_end;
      s1_byp      <= s1_done && (s1_col == col_cur);
      byp_a       <= win[0];
      byp_b       <= win[1];
      byp_c       <= win[2];
    end
  end

  always_comb begin
    win[0] = s1_pix;
    win[1] = s1_byp ? byp_a : rd_a;
    win[2] = s1_byp ? byp_b : rd_b;
    win[3] = s1_byp ? byp_c : rd_c;
  end

  fvqs_kernel u_kernel (
    .win           (win),
    .cur_row       (s1_row),
    .height        (h_eff),
    .last_col      (s1_last_col),
    .kernel_select (kernel_select),
    .shift_up      (shift_up),
    .grp           (grp)
  );

  // Output stage control: number of results still to send
  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= 2'd0;
    end else if (s1_done && grp.count != 2'd0) begin
      out_cnt <= grp.count;
    end else if (out_xfer) begin
      out_cnt <= out_cnt - 2'd1;
    end
  end

  // Output stage payload: load a group, shift it down one slot per transfer
  always_ff @(posedge clk) begin
    if (s1_done && grp.count != 2'd0) begin
      out_grp   <= grp;
      out_col_q <= s1_col;
    end else if (out_xfer) begin
      for (int j = 0; j < SLOTS - 1; j++) begin
        out_grp.row[j] <= out_grp.row[j+1];
        out_grp.pix[j] <= out_grp.pix[j+1];
        out_grp.eof[j] <= out_grp.eof[j+1];
      end
    end
  end

  assign out_valid     = (out_cnt != 2'd0);
  assign pixel_out     = out_grp.pix[0];
  assign out_row       = out_grp.row[0];
  assign out_col       = out_col_q;
  assign last_of_item  = (out_cnt == 2'd1);
  assign last_of_field = out_grp.eof[0];

endmodule
